FILE: hw/rtl/rgb_frame_convolution_2d_macros.svh
// assertion macros shared by the convolution block
`ifndef RGB_FRAME_CONVOLUTION_2D_MACROS_SVH
`define RGB_FRAME_CONVOLUTION_2D_MACROS_SVH

// same-cycle implication, checked at each rising edge outside reset
`define RFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("convolution block check failed");

// next-cycle implication
`define RFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("convolution block check failed");

`endif

FILE: hw/rtl/rfc2d_pkg.sv
// types and constants of the rgb frame convolution block
package rfc2d_pkg;

    localparam int DEF_MAX_KERNEL     = 15;
    localparam int DEF_MAX_WIDTH      = 64;
    localparam int DEF_MAX_HEIGHT     = 64;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int FRAME_AW  = 12;
    localparam int PIX_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int COEF_W    = 16;
    localparam int KSIZE_W   = 4;
    localparam int FDIM_W    = 7;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;
    localparam int IN_DATA_W = 64;
    localparam int PROD_W    = COEF_W + CHAN_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_COEF  = 2'd0,
        OP_LOAD_PIXEL = 2'd1,
        OP_CONVOLVE   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic clr;
        logic vld;
        logic inb;
    } t_mac_ctl;

endpackage

FILE: hw/rtl/rfc2d_mac.sv
// three-lane multiply-accumulate with absolute value and saturation
module rfc2d_mac #(
    parameter int COEF_FRAC_BITS = rfc2d_pkg::DEF_COEF_FRAC_BITS,
    parameter int ACC_W          = 34
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rfc2d_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [rfc2d_pkg::COEF_W-1:0]  i_coef,
    input  logic [rfc2d_pkg::PIX_W-1:0]          i_pixel,
    output logic                                 o_busy,
    output logic [rfc2d_pkg::PIX_W-1:0]          o_res
);
    import rfc2d_pkg::*;

    logic                     r_pv;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc  [3];

    function automatic logic [CHAN_W-1:0] sat_mag(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] sh;
        mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        sh  = mag >> COEF_FRAC_BITS;
        return (sh > ACC_W'(255)) ? {CHAN_W{1'b1}} : sh[CHAN_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.vld;
        end
    end

    // taps outside the frame enter as zero products
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_ctl.inb) begin
                r_prod[k] <= i_coef * $signed({1'b0, i_pixel[k*CHAN_W +: CHAN_W]});
            end else begin
                r_prod[k] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_ctl.clr) begin
                r_acc[k] <= '0;
            end else if (r_pv) begin
                r_acc[k] <= r_acc[k] + ACC_W'(r_prod[k]);
            end
        end
    end

    assign o_busy = r_pv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_res[k*CHAN_W +: CHAN_W] = sat_mag(r_acc[k]);
        end
    end

endmodule

FILE: hw/rtl/rgb_frame_convolution_2d.sv
// 2-d convolution of a stored rgb frame with zero padding, one output pixel per request
// coefficient and pixel loads are taken in idle without a state change; ready stays high for them
// an output pixel request runs one tap per cycle through the tap pipeline into the
// shared three-lane mac, set by the single read port of the frame memory, then drains the pipe
// ready is low from a request until its result moves to the output register
// synchronous active-low reset returns to idle with kernel 3 and a 64x64 frame
`include "rgb_frame_convolution_2d_macros.svh"
module rgb_frame_convolution_2d #(
    parameter int MAX_KERNEL     = rfc2d_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH      = rfc2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = rfc2d_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_FRAC_BITS = rfc2d_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfc2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rfc2d_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // index[11:0], coef[27:12], in_red[35:28], in_green[43:36], in_blue[51:44],
    // out_line[57:52], out_pixel[63:58]
    input  logic [rfc2d_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // res_red[7:0], res_green[15:8], res_blue[23:16]
    output logic [rfc2d_pkg::PIX_W-1:0]         m_axis_tdata
);
    import rfc2d_pkg::*;

    localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int IW         = $clog2(64 + MAX_KERNEL) + 1;
    localparam int ACC_W      = PROD_W + CAW + 1;

    // configuration
    logic [KSIZE_W-1:0] r_kernel_size;
    logic [FDIM_W-1:0]  r_frame_width;
    logic [FDIM_W-1:0]  r_frame_height;

    // sequencer
    t_state             r_state, n_state;
    logic [KSIZE_W-1:0] r_m, r_n;
    logic [CAW-1:0]     r_ci;
    logic [POS_W-1:0]   r_line, r_col;

    // tap pipeline
    logic                r_v1, r_inb1, r_v2, r_inb2;
    logic [FRAME_AW-1:0] r_addr1;
    logic [COEF_W-1:0]   r_coef_rd, r_coef2;
    logic [PIX_W-1:0]    r_pix_rd;

    // output register
    logic             r_m_valid;
    logic [PIX_W-1:0] r_m_data;

    // memories
    logic [COEF_W-1:0] r_coef_mem  [COEF_DEPTH];
    logic [PIX_W-1:0]  r_frame_mem [2**FRAME_AW];

    logic                in_acc, req_conv, issue, last_tap, load_out, pipe_empty;
    t_op                 in_op;
    logic [FRAME_AW-1:0] in_index;
    logic [KSIZE_W-1:0]  size;
    logic [2:0]          center;
    logic [FDIM_W-1:0]   w_eff, h_eff;
    logic [IW-1:0]       ii, jj;
    logic                inb;
    logic                mac_busy;
    logic [PIX_W-1:0]    mac_res;
    t_mac_ctl            mac_ctl;

    assign in_op    = t_op'(s_axis_tuser);
    assign in_index = s_axis_tdata[11:0];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign req_conv = in_acc && (in_op == OP_CONVOLVE);

    assign size   = (r_kernel_size > MAX_KERNEL) ? KSIZE_W'(MAX_KERNEL) : r_kernel_size;
    assign center = size[3:1];
    assign w_eff  = (r_frame_width > MAX_WIDTH) ? FDIM_W'(MAX_WIDTH) : r_frame_width;
    assign h_eff  = (r_frame_height > MAX_HEIGHT) ? FDIM_W'(MAX_HEIGHT) : r_frame_height;

    assign last_tap   = (r_m == size - 1'b1) && (r_n == size - 1'b1);
    assign pipe_empty = !r_v1 && !r_v2 && !mac_busy;

    // window position of the current tap, negative when above or left of the frame
    assign ii  = IW'(r_line) + IW'(r_m) - IW'(center);
    assign jj  = IW'(r_col) + IW'(r_n) - IW'(center);
    assign inb = !ii[IW-1] && (ii < IW'(h_eff)) && !jj[IW-1] && (jj < IW'(w_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_size  <= KSIZE_W'(3);
            r_frame_width  <= FDIM_W'(64);
            r_frame_height <= FDIM_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KERNEL_SIZE:  r_kernel_size  <= i_cfg_data[KSIZE_W-1:0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_conv) begin
                    n_state = (size == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_RUN:   issue = 1'b1;
            ST_DRAIN: ;
            ST_FIN:   load_out = !r_m_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m  <= '0;
            r_n  <= '0;
            r_ci <= '0;
        end else if (req_conv) begin
            r_m  <= '0;
            r_n  <= '0;
            r_ci <= '0;
        end else if (issue) begin
            r_ci <= r_ci + 1'b1;
            if (r_n == size - 1'b1) begin
                r_n <= '0;
                r_m <= r_m + 1'b1;
            end else begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_conv) begin
            r_line <= s_axis_tdata[57:52];
            r_col  <= s_axis_tdata[63:58];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    // address is line*width+pixel, kept to the low 12 bits
    always_ff @(posedge i_clk) begin
        r_inb1  <= inb;
        r_addr1 <= FRAME_AW'(ii) * FRAME_AW'(w_eff) + FRAME_AW'(jj);
        r_inb2  <= r_inb1;
        r_coef2 <= r_coef_rd;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (in_op == OP_LOAD_COEF) && (in_index < COEF_DEPTH)) begin
            r_coef_mem[in_index[CAW-1:0]] <= s_axis_tdata[27:12];
        end
        r_coef_rd <= r_coef_mem[r_ci];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (in_op == OP_LOAD_PIXEL)) begin
            r_frame_mem[in_index] <= s_axis_tdata[51:28];
        end
        r_pix_rd <= r_frame_mem[r_addr1];
    end

    assign mac_ctl.clr = req_conv;
    assign mac_ctl.vld = r_v2;
    assign mac_ctl.inb = r_inb2;

    rfc2d_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .ACC_W          (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  ($signed(r_coef2)),
        .i_pixel (r_pix_rd),
        .o_busy  (mac_busy),
        .o_res   (mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_data <= mac_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `RFC_ASSERT_NEXT(a_conv_starts, req_conv && (size != '0), r_state == ST_RUN)
    `RFC_ASSERT_NOW(a_idle_pipe_empty, r_state == ST_IDLE, !r_v1 && !r_v2 && !mac_busy)
    `RFC_ASSERT_NOW(a_result_from_fin, $rose(r_m_valid), $past(r_state) == ST_FIN)
    `RFC_ASSERT_NEXT(a_drain_after_last, issue && last_tap, r_state == ST_DRAIN && r_v1)

endmodule
